// ===== hdl/nmea_sentence_framer_unit_defines.svh =====
`ifndef NMEA_SENTENCE_FRAMER_UNIT_DEFINES_SVH
`define NMEA_SENTENCE_FRAMER_UNIT_DEFINES_SVH

// Same-cycle check: whenever the antecedent holds, the consequent must hold too.
`define NSF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle check: the consequent must hold in the cycle after the antecedent.
`define NSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/nsf_pkg.sv =====
package nsf_pkg;

    // Framing phase of the sentence currently being received.
    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_HEADER = 2'd1,
        PH_BODY   = 2'd2,
        PH_TAIL   = 2'd3
    } phase_t;

    // End status codes carried on end transactions.
    typedef enum logic [1:0] {
        ST_GOOD  = 2'd0,
        ST_BAD   = 2'd1,
        ST_ABORT = 2'd2
    } end_status_t;

    localparam int          KIND_COUNT = 5;
    localparam int          HDR_LEN    = 7;
    localparam logic [7:0]  XOR_SEED   = 8'h0E;
    localparam logic [7:0]  CH_DOLLAR  = 8'h24;
    localparam logic [7:0]  CH_COMMA   = 8'h2C;
    localparam logic [7:0]  CH_STAR    = 8'h2A;
    localparam logic [7:0]  CH_NEWLINE = 8'h0A;

    // Header strings, one row per sentence kind in kind-code order.
    localparam logic [7:0] HDR_TAB [0:KIND_COUNT-1][0:HDR_LEN-1] = '{
        '{8'h24, 8'h47, 8'h4E, 8'h52, 8'h4D, 8'h43, 8'h2C},  // $GNRMC,
        '{8'h24, 8'h47, 8'h4E, 8'h47, 8'h47, 8'h41, 8'h2C},  // $GNGGA,
        '{8'h24, 8'h47, 8'h4E, 8'h47, 8'h53, 8'h41, 8'h2C},  // $GNGSA,
        '{8'h24, 8'h47, 8'h50, 8'h47, 8'h53, 8'h56, 8'h2C},  // $GPGSV,
        '{8'h24, 8'h47, 8'h4C, 8'h47, 8'h53, 8'h56, 8'h2C}   // $GLGSV,
    };

    // True for 0-9, A-F and a-f.
    function automatic logic hex_digit(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    // Nibble value of a hex digit; zero for anything else.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

endpackage

// ===== hdl/nmea_sentence_framer_unit.sv =====
// Channel   Dir  Width   Contents
// s_axis    in   8       tdata: received serial byte
// m_axis    out  16+3+1  tdata: field number, field char, end status; tuser: kind; tlast: end
//
// One byte per clock is accepted while m_axis is not stalled; a byte that yields a result
// raises m_axis_tvalid once its result is in the result register. The byte lands in an input
// register, the framing logic evaluates it in one pass and writes the result register together
// with the framing state. aresetn (synchronous, active low) returns framing to hunting for '$'
// and empties both registers. A stalled m_axis holds the result; the input register keeps one
// byte, so s_axis_tready drops only when both registers are full and the output is stalled.
module nmea_sentence_framer_unit
    import nsf_pkg::*;
#(
    parameter int MAX_LEN    = 256,
    parameter int MAX_FIELDS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [4:0] field_number, [12:5] field_char,
                                        // [14:13] end_status, [15] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] sentence_kind
    output logic        m_axis_tlast    // is_end
);

    `include "nmea_sentence_framer_unit_defines.svh"

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int FW = $clog2(MAX_FIELDS);
    localparam logic [LW-1:0] LEN_LIMIT   = LW'(MAX_LEN);
    localparam logic [FW:0]   FIELD_LIMIT = (FW + 1)'(MAX_FIELDS);

    // Input register.
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;

    // Framing state.
    phase_t      phase_reg, phase_next;
    logic [2:0]  header_pos_reg, header_pos_next;
    logic [KIND_COUNT-1:0] cand_reg, cand_next;
    logic [2:0]  kind_reg, kind_next;
    logic [7:0]  xor_reg, xor_next;
    logic [FW-1:0] field_count_reg, field_count_next;
    logic [LW-1:0] length_reg, length_next;
    logic [23:0] tail_reg, tail_next;

    // Result register.
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  out_kind_reg, out_kind_next;
    logic [4:0]  out_field_reg, out_field_next;
    logic [7:0]  out_char_reg, out_char_next;
    logic        out_end_reg, out_end_next;
    end_status_t out_status_reg, out_status_next;

    logic        advance;
    logic        start;
    logic        res_valid;
    logic [KIND_COUNT-1:0] match;
    logic        sum_ok;

    // The input register moves on when the result register can take its outcome.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_status_reg, out_char_reg, out_field_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_end_reg;

    // Checksum comparison against the two hex digits that precede the byte before the newline.
    assign sum_ok = hex_digit(tail_reg[23:16]) && hex_digit(tail_reg[15:8]) &&
                    !hex_digit(tail_reg[7:0]) &&
                    ({hex_value(tail_reg[23:16]), hex_value(tail_reg[15:8])} == xor_reg);

    // Header byte compare against every sentence kind at the current position.
    always_comb begin
        match = '0;
        for (int k = 0; k < KIND_COUNT; k++) begin
            if (header_pos_reg < 3'(HDR_LEN)) begin
                match[k] = (HDR_TAB[k][header_pos_reg] == in_byte_reg);
            end
        end
    end

    // Framing next state and result.
    always_comb begin
        phase_next       = phase_reg;
        header_pos_next  = header_pos_reg;
        cand_next        = cand_reg;
        kind_next        = kind_reg;
        xor_next         = xor_reg;
        field_count_next = field_count_reg;
        length_next      = length_reg;
        tail_next        = tail_reg;
        start            = 1'b0;
        res_valid        = 1'b0;
        out_char_next    = 8'h00;
        out_end_next     = 1'b0;
        out_status_next  = ST_GOOD;

        if (advance) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    start = (in_byte_reg == CH_DOLLAR);
                end
                PH_HEADER: begin
                    if (in_byte_reg == CH_DOLLAR) begin
                        start = 1'b1;
                    end else if (header_pos_reg >= 3'(HDR_LEN)) begin
                        phase_next = PH_HUNT;
                    end else begin
                        length_next = LW'(length_reg + 1'b1);
                        cand_next   = cand_reg & match;
                        if ((cand_reg & match) == '0) begin
                            phase_next = PH_HUNT;
                        end else begin
                            xor_next        = xor_reg ^ in_byte_reg;
                            header_pos_next = 3'(header_pos_reg + 1'b1);
                            if (header_pos_reg == 3'(HDR_LEN - 1)) begin
                                // Lowest surviving candidate names the kind.
                                for (int k = KIND_COUNT - 1; k >= 0; k--) begin
                                    if (cand_reg[k] && match[k]) begin
                                        kind_next = 3'(k);
                                    end
                                end
                                field_count_next = '0;
                                phase_next       = PH_BODY;
                            end
                        end
                    end
                end
                PH_BODY, PH_TAIL: begin
                    if (in_byte_reg == CH_DOLLAR) begin
                        res_valid       = 1'b1;
                        out_end_next    = 1'b1;
                        out_status_next = ST_ABORT;
                        start           = 1'b1;
                    end else if (length_reg >= LEN_LIMIT) begin
                        res_valid       = 1'b1;
                        out_end_next    = 1'b1;
                        out_status_next = ST_ABORT;
                        phase_next      = PH_HUNT;
                    end else begin
                        length_next = LW'(length_reg + 1'b1);
                        if (phase_reg == PH_BODY) begin
                            xor_next = xor_reg ^ in_byte_reg;
                            if (in_byte_reg == CH_COMMA) begin
                                if ({1'b0, field_count_reg} + 1'b1 >= FIELD_LIMIT) begin
                                    res_valid       = 1'b1;
                                    out_end_next    = 1'b1;
                                    out_status_next = ST_BAD;
                                    phase_next      = PH_HUNT;
                                end else begin
                                    field_count_next = FW'(field_count_reg + 1'b1);
                                end
                            end else if (in_byte_reg == CH_STAR) begin
                                phase_next = PH_TAIL;
                                tail_next  = '0;
                            end else begin
                                res_valid     = 1'b1;
                                out_char_next = in_byte_reg;
                            end
                        end else if (in_byte_reg == CH_NEWLINE) begin
                            res_valid       = 1'b1;
                            out_end_next    = 1'b1;
                            out_status_next = sum_ok ? ST_GOOD : ST_BAD;
                            phase_next      = PH_HUNT;
                        end else begin
                            tail_next = {tail_reg[15:0], in_byte_reg};
                        end
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end

        // A '$' opens a new sentence with the dollar already counted.
        if (start) begin
            phase_next       = PH_HEADER;
            header_pos_next  = 3'd1;
            cand_next        = '1;
            xor_next         = XOR_SEED ^ CH_DOLLAR;
            length_next      = LW'(1);
            field_count_next = '0;
            tail_next        = '0;
        end

        // Results are tagged with the kind and field before this byte's update.
        out_kind_next  = kind_reg;
        out_field_next = 5'(field_count_reg);

        // Input register: a taken byte refills it, otherwise it empties on advance.
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        // Result register: loaded on advance, emptied when taken.
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = res_valid;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= PH_HUNT;
            header_pos_reg  <= 3'd0;
            cand_reg        <= '1;
            kind_reg        <= 3'd0;
            xor_reg         <= 8'h00;
            field_count_reg <= '0;
            length_reg      <= '0;
            tail_reg        <= '0;
        end else begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            phase_reg       <= phase_next;
            header_pos_reg  <= header_pos_next;
            cand_reg        <= cand_next;
            kind_reg        <= kind_next;
            xor_reg         <= xor_next;
            field_count_reg <= field_count_next;
            length_reg      <= length_next;
            tail_reg        <= tail_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
        end
        if (advance) begin
            out_kind_reg   <= out_kind_next;
            out_field_reg  <= out_field_next;
            out_char_reg   <= out_char_next;
            out_end_reg    <= out_end_next;
            out_status_reg <= out_status_next;
        end
    end

    // Field characters always carry a good status and are never a dollar, and kinds stay in range.
    `NSF_ASSERT_NOW(a_char_status, m_axis_tvalid && !m_axis_tlast,
        m_axis_tdata[14:13] == ST_GOOD && m_axis_tdata[12:5] != CH_DOLLAR,
        "field character with end status or a dollar")
    `NSF_ASSERT_NOW(a_kind_range, m_axis_tvalid, m_axis_tuser < 3'(KIND_COUNT),
        "sentence kind out of range")
    // Counters never pass their limits.
    `NSF_ASSERT_NOW(a_limits, 1'b1,
        length_reg <= LEN_LIMIT && (FW + 1)'(field_count_reg) < FIELD_LIMIT,
        "length or field counter past its limit")
    // A byte that cannot advance is kept in the input register.
    `NSF_ASSERT_NEXT(a_in_hold, in_valid_reg && !advance,
        in_valid_reg && $stable(in_byte_reg), "input byte lost while stalled")

endmodule
